[rtl/core/chs_pkg.sv]
// Shared constants and types for the 3x3 Canny hysteresis block.
package chs_pkg;

   // Frame limits
   localparam int unsigned MAX_COLS = 2048;
   localparam int unsigned MAX_ROWS = 2048;
   localparam int unsigned MIN_SIZE = 3;

   // Field and counter widths
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned SIZE_W   = 12;
   localparam int unsigned COL_W    = $clog2(MAX_COLS);
   localparam int unsigned ROW_W    = 12;
   localparam int unsigned TOTAL_W  = $clog2(MAX_COLS) + $clog2(MAX_ROWS) + 1;
   localparam int unsigned OPC_W    = TOTAL_W - 1;
   localparam int unsigned CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEAK_LEVEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRONG_LEVEL = 2'd3;

   // Reset values of the configuration registers
   localparam logic [SIZE_W-1:0] FRAME_ROWS_RST   = 12'd1080;
   localparam logic [SIZE_W-1:0] FRAME_COLS_RST   = 12'd1920;
   localparam logic [PIX_W-1:0]  WEAK_LEVEL_RST   = 8'd90;
   localparam logic [PIX_W-1:0]  STRONG_LEVEL_RST = 8'd255;

   // Result queue depth
   localparam int unsigned OQ_DEPTH = 3;
   localparam int unsigned OQ_PTR_W = 2;
   localparam int unsigned OQ_CNT_W = 2;

   // Per-pixel control that travels with a transaction into the window stage
   typedef struct packed {
      logic emit;     // this transaction produces a result
      logic border;   // result pixel lies on the frame border
      logic last;     // result is the final pixel of the frame
   } pix_info_type;

endpackage

[rtl/core/chs_ram.sv]
// Generic simple dual-port RAM with registered read.
module chs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/chs_ctrl.sv]
// Frame position counters, size clamping and per-pixel control decode.
module chs_ctrl import chs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] frame_rows,
   input  logic [SIZE_W-1:0] frame_cols,
   input  logic              accept,
   output logic [COL_W-1:0]  col,
   output pix_info_type      info
);

   logic [SIZE_W-1:0]   rows_cl;
   logic [SIZE_W-1:0]   cols_cl;
   logic [TOTAL_W-1:0]  total;
   logic [2*SIZE_W-1:0] product;

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [OPC_W-1:0]   opc_ff, opc_in;

   logic [SIZE_W-1:0]  col_plus;
   logic [TOTAL_W-1:0] opc_plus;
   logic               row_wrap;
   logic               emit;
   logic               border;
   logic               last;

   // Clamp the frame size and form the pixel count
   always_comb begin
      if (frame_rows < SIZE_W'(MIN_SIZE)) begin
         rows_cl = SIZE_W'(MIN_SIZE);
      end else if (frame_rows > SIZE_W'(MAX_ROWS)) begin
         rows_cl = SIZE_W'(MAX_ROWS);
      end else begin
         rows_cl = frame_rows;
      end
      if (frame_cols < SIZE_W'(MIN_SIZE)) begin
         cols_cl = SIZE_W'(MIN_SIZE);
      end else if (frame_cols > SIZE_W'(MAX_COLS)) begin
         cols_cl = SIZE_W'(MAX_COLS);
      end else begin
         cols_cl = frame_cols;
      end
   end

   assign product = rows_cl * cols_cl;
   assign total   = product[TOTAL_W-1:0];

   // Decode the current position
   assign col_plus = {{(SIZE_W-COL_W){1'b0}}, col_ff} + SIZE_W'(1);
   assign row_wrap = (col_plus >= cols_cl);
   assign opc_plus = {1'b0, opc_ff} + TOTAL_W'(1);
   assign emit     = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
   assign border   = (col_ff < COL_W'(2)) || (row_ff < ROW_W'(2)) || (row_ff >= rows_cl);
   assign last     = emit && (opc_plus >= total);

   // Next counter values
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      opc_in = opc_ff;
      if (accept) begin
         if (last) begin
            row_in = '0;
            col_in = '0;
            opc_in = '0;
         end else begin
            if (row_wrap) begin
               col_in = '0;
               if (row_ff != '1) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_plus[COL_W-1:0];
            end
            if (emit) begin
               opc_in = opc_plus[OPC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         opc_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         opc_ff <= opc_in;
      end
   end

   assign col         = col_ff;
   assign info.emit   = emit;
   assign info.border = border;
   assign info.last   = last;

endmodule

[rtl/core/chs_window.sv]
// 3x3 window registers and the weak/strong neighbour test.
module chs_window import chs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [PIX_W-1:0] pix_up,
   input  logic [PIX_W-1:0] pix_lo,
   input  logic [PIX_W-1:0] pix_cur,
   input  logic             border,
   input  logic [PIX_W-1:0] weak_level,
   input  logic [PIX_W-1:0] strong_level,
   output logic [PIX_W-1:0] result
);

   // Older two window columns, row 0 on top; the newest comes from the inputs
   logic [PIX_W-1:0] mid_ff [3];
   logic [PIX_W-1:0] mid_in [3];
   logic [PIX_W-1:0] new_ff [3];
   logic [PIX_W-1:0] new_in [3];
   logic [PIX_W-1:0] nbr    [8];
   logic [PIX_W-1:0] center;
   logic             hit;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mid_in[i] = shift ? new_ff[i] : mid_ff[i];
      end
      new_in[0] = shift ? pix_up  : new_ff[0];
      new_in[1] = shift ? pix_lo  : new_ff[1];
      new_in[2] = shift ? pix_cur : new_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            mid_ff[i] <= '0;
            new_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            mid_ff[i] <= mid_in[i];
            new_ff[i] <= new_in[i];
         end
      end
   end

   // Test on the window as it stands after this shift
   assign center = new_ff[1];
   assign nbr[0] = mid_ff[0];
   assign nbr[1] = new_ff[0];
   assign nbr[2] = pix_up;
   assign nbr[3] = mid_ff[1];
   assign nbr[4] = pix_lo;
   assign nbr[5] = mid_ff[2];
   assign nbr[6] = new_ff[2];
   assign nbr[7] = pix_cur;

   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (nbr[k] == strong_level) begin
            hit = 1'b1;
         end
      end
      if (border) begin
         result = '0;
      end else if (center == weak_level) begin
         result = hit ? strong_level : '0;
      end else begin
         result = center;
      end
   end

endmodule

[rtl/core/chs_outq.sv]
// Three-entry result queue that decouples the pipeline from the result consumer.
module chs_outq import chs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [PIX_W-1:0] push_pixel,
   input  logic             push_last,
   input  logic             inflight,
   output logic             space,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   logic [PIX_W-1:0]    pix_ff  [OQ_DEPTH];
   logic                last_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] head_ff, head_in;
   logic [OQ_PTR_W-1:0] tail_ff, tail_in;
   logic [OQ_CNT_W-1:0] count_ff, count_in;
   logic [OQ_CNT_W:0]   load;
   logic                pop;

   assign pop = rsp_tvalid && rsp_tready;

   // Pointer and fill bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : head_ff + OQ_PTR_W'(1);
      end
      if (push) begin
         tail_in = (tail_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : tail_ff + OQ_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + OQ_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pix_ff[tail_ff]  <= push_pixel;
         last_ff[tail_ff] <= push_last;
      end
   end

   // Room for one more transaction counting the one still in the window stage
   assign load  = {1'b0, count_ff} + {{OQ_CNT_W{1'b0}}, inflight};
   assign space = (load < (OQ_CNT_W+1)'(OQ_DEPTH));

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = pix_ff[head_ff];
   assign rsp_tlast  = last_ff[head_ff];

endmodule

[rtl/core/canny_hysteresis_3x3.sv]
// Canny hysteresis edge tracking over a raster pixel stream with a 3x3 window.
//
// Takes one pixel per clock on req_ and returns one result per clock on rsp_.
// A result leaves the block once the transaction that completes its window has
// passed the line-store read, then the window test; in stream terms each result
// belongs to the pixel frame_cols + 1 transactions earlier, so after the last
// pixel of a frame the source sends frame_cols + 1 pad transactions
// (req_tuser = 1) to drain it. Border pixels come out as 0. The two line stores
// share one 2048 x 16 RAM with one read and one write port; rate is set by
// that port pair and a three-deep result queue, and holds at one pixel per
// clock while rsp_tready stays high. Frame size and levels are written on the
// csr_ port between frames; a write applies from the next transaction on.
module canny_hysteresis_3x3 import chs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Pixel input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIX_W-1:0]     req_tdata,   // [7:0] pixel_in
   input  logic                 req_tuser,   // [0] pad
   // Result output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,   // [7:0] pixel_out
   output logic                 rsp_tlast,
   // Configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   logic [SIZE_W-1:0] frame_rows_ff, frame_cols_ff;
   logic [PIX_W-1:0]  weak_level_ff, strong_level_ff;

   logic              accept;
   logic [PIX_W-1:0]  pix_s0;
   logic [COL_W-1:0]  col_s0;
   pix_info_type      info_s0;

   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   pix_info_type      s1_info_ff;

   logic [2*PIX_W-1:0] ram_rd;
   logic [2*PIX_W-1:0] ram_wr;
   logic [PIX_W-1:0]   pix_up, pix_lo;
   logic [PIX_W-1:0]   result;
   logic               space;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff   <= FRAME_ROWS_RST;
         frame_cols_ff   <= FRAME_COLS_RST;
         weak_level_ff   <= WEAK_LEVEL_RST;
         strong_level_ff <= STRONG_LEVEL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_ROWS:   frame_rows_ff   <= csr_data;
            CSR_FRAME_COLS:   frame_cols_ff   <= csr_data;
            CSR_WEAK_LEVEL:   weak_level_ff   <= csr_data[PIX_W-1:0];
            CSR_STRONG_LEVEL: strong_level_ff <= csr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage
   assign req_tready = space;
   assign accept     = req_tvalid && req_tready;
   assign pix_s0     = req_tuser ? '0 : req_tdata;

   chs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .frame_rows (frame_rows_ff),
      .frame_cols (frame_cols_ff),
      .accept     (accept),
      .col        (col_s0),
      .info       (info_s0)
   );

   // Line stores: upper row in the high byte, lower row in the low byte
   assign pix_up = ram_rd[2*PIX_W-1:PIX_W];
   assign pix_lo = ram_rd[PIX_W-1:0];
   assign ram_wr = {pix_lo, s1_pix_ff};

   chs_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (MAX_COLS)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr),
      .rd_en   (accept),
      .rd_addr (col_s0),
      .rd_data (ram_rd)
   );

   // Window stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix_s0;
         s1_col_ff  <= col_s0;
         s1_info_ff <= info_s0;
      end
   end

   chs_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift        (s1_valid_ff),
      .pix_up       (pix_up),
      .pix_lo       (pix_lo),
      .pix_cur      (s1_pix_ff),
      .border       (s1_info_ff.border),
      .weak_level   (weak_level_ff),
      .strong_level (strong_level_ff),
      .result       (result)
   );

   chs_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff && s1_info_ff.emit),
      .push_pixel (result),
      .push_last  (s1_info_ff.last),
      .inflight   (s1_valid_ff),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/core/chs_checker.sv]
// Port-level checks for the hysteresis block, bound to the top level.
module chs_checker import chs_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [PIX_W-1:0]     rsp_tdata,
   input logic                 rsp_tlast,
   input logic                 csr_ready
);

   // A held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // Input only backs up when results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // Configuration writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind canny_hysteresis_3x3 chs_checker u_chs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

[tb/canny_hysteresis_3x3_tb.sv]
// Self-checking testbench for the 3x3 Canny hysteresis stream block.
`timescale 1ns / 100ps

module canny_hysteresis_3x3_tb;
   import chs_pkg::*;

   localparam int SETTLE_CYCLES = 10;   // pause around idle points and at the end
   localparam int LONG_HOLD     = 300;  // receiver hold-off that backs up the block

   // One pixel transaction and one result transaction
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             pad;
   } pixel_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } edge_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata = '0;   // [7:0] pixel_in
   logic                 req_tuser = 1'b0; // [0] pad
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;        // [7:0] pixel_out
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_data = '0;

   canny_hysteresis_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Stimulus and expectation stores
   pixel_item_type  pixel_q[$];
   edge_result_type expected_pixels[$];
   int              items_open = 0;
   int              mismatch_cnt = 0;

   // Idling controls
   bit idle_on = 1'b0;
   int send_gap = 0;
   int recv_stall = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Predictor copy of configuration and state
   logic [SIZE_W-1:0] cfg_rows = FRAME_ROWS_RST;
   logic [SIZE_W-1:0] cfg_cols = FRAME_COLS_RST;
   logic [PIX_W-1:0]  cfg_weak = WEAK_LEVEL_RST;
   logic [PIX_W-1:0]  cfg_strong = STRONG_LEVEL_RST;
   bit [PIX_W-1:0]    line_upper [MAX_COLS];
   bit [PIX_W-1:0]    line_lower [MAX_COLS];
   bit [PIX_W-1:0]    win [3][3];
   int unsigned       in_row = 0;
   int unsigned       in_col = 0;
   int unsigned       out_cnt = 0;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Hysteresis prediction for one accepted pixel transaction
   task automatic track_pixel(input logic [PIX_W-1:0] pix_in, input logic pad);
      int unsigned      rows, cols, total, r, c;
      logic [PIX_W-1:0] p, up, lo;
      bit               hit;
      edge_result_type  er;
      rows = clamp_dim(cfg_rows, MAX_ROWS);
      cols = clamp_dim(cfg_cols, MAX_COLS);
      total = rows * cols;
      r = in_row;
      c = in_col;
      p = pad ? '0 : pix_in;
      if (c >= MAX_COLS) c = 0;

      // column of rows r-2, r-1, r
      up = line_upper[c];
      lo = line_lower[c];
      line_upper[c] = lo;
      line_lower[c] = p;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = p;

      if (c + 1 >= cols) begin
         in_col = 0;
         if (in_row < 'hFFF) in_row++;
      end else begin
         in_col = c + 1;
      end

      if (!(r >= 2 || (r == 1 && c >= 1))) return;

      // window center is the result pixel
      if (c < 2 || r < 2 || r >= rows) begin
         er.pix = '0;
      end else if (win[1][1] == cfg_weak) begin
         hit = 1'b0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               if (!(i == 1 && j == 1) && win[i][j] == cfg_strong) hit = 1'b1;
         er.pix = hit ? cfg_strong : '0;
      end else begin
         er.pix = win[1][1];
      end

      if (out_cnt + 1 >= total) begin
         er.last = 1'b1;
         out_cnt = 0;
         in_row = 0;
         in_col = 0;
      end else begin
         er.last = 1'b0;
         out_cnt++;
      end
      expected_pixels.push_back(er);
   endtask

   // Pixel driver
   always @(posedge clock) begin
      pixel_item_type nxt;
      logic           nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            track_pixel(req_tdata, req_tuser);
            items_open--;
            nxt_valid = 1'b0;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pixel_q.size() > 0) begin
               nxt = pixel_q.pop_front();
               req_tdata <= nxt.pix;
               req_tuser <= nxt.pad;
               nxt_valid = 1'b1;
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out: unexpected result transaction, got %0d", rsp_tdata);
               mismatch_cnt++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pix) begin
                  $error("pixel_out: expected %0d, actual %0d", want.pix, rsp_tdata);
                  mismatch_cnt++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_last: expected %0d, actual %0d", want.last, rsp_tlast);
                  mismatch_cnt++;
               end
            end
         end

         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 15);
         end
      end
   end

   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic pad);
      pixel_item_type it;
      it.pix = pix;
      it.pad = pad;
      pixel_q.push_back(it);
      items_open++;
   endtask

   // Wait until every transaction is in and every result is out
   task automatic wait_idle();
      while (items_open != 0 || expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_ROWS:   cfg_rows = val;
         CSR_FRAME_COLS:   cfg_cols = val;
         CSR_WEAK_LEVEL:   cfg_weak = val[PIX_W-1:0];
         CSR_STRONG_LEVEL: cfg_strong = val[PIX_W-1:0];
      endcase
   endtask

   // Idle the block, then load all four registers; level writes carry junk upper bits
   task automatic configure(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                            input logic [PIX_W-1:0] weak_lvl,
                            input logic [PIX_W-1:0] strong_lvl);
      wait_idle();
      write_csr(CSR_FRAME_ROWS, rows);
      write_csr(CSR_FRAME_COLS, cols);
      write_csr(CSR_WEAK_LEVEL, {4'($urandom_range(0, 15)), weak_lvl});
      write_csr(CSR_STRONG_LEVEL, {4'($urandom_range(0, 15)), strong_lvl});
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One full frame plus its drain transactions, biased toward weak and strong levels
   task automatic queue_frame(input int unsigned rows, input int unsigned cols);
      logic [PIX_W-1:0] p;
      for (int k = 0; k < rows * cols; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: p = cfg_weak;
            3, 4:    p = cfg_strong;
            5:       p = '0;
            6:       p = '1;
            default: p = PIX_W'($urandom);
         endcase
         push_pixel(p, $urandom_range(0, 29) == 0);
      end
      // drain: mostly pads, some real pixels that must not matter
      for (int k = 0; k <= cols; k++)
         push_pixel(PIX_W'($urandom), $urandom_range(0, 3) != 0);
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                            input logic [PIX_W-1:0] weak_lvl,
                            input logic [PIX_W-1:0] strong_lvl,
                            input int min_items, input bit bursty);
      int unsigned r, c;
      int          sent;
      configure(rows, cols, weak_lvl, strong_lvl);
      r = clamp_dim(rows, MAX_ROWS);
      c = clamp_dim(cols, MAX_COLS);
      sent = 0;
      while (sent < min_items) begin
         idle_on = bursty && ($urandom_range(0, 3) != 0);
         queue_frame(r, c);
         sent += r * c + c + 1;
         wait_idle();
      end
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: weak center next to a strong pixel, with a real pixel in the drain
      configure(12'd3, 12'd3, 8'd90, 8'd255);
      idle_on = 1'b1;
      push_pixel(8'd0, 1'b0);   push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
      push_pixel(8'd7, 1'b0);   push_pixel(8'd90, 1'b0);  push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b0);   push_pixel(8'd0, 1'b0);   push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b1); push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b1);
      push_pixel(8'd0, 1'b1);
      // Directed: weak center, only near-strong neighbors, a pad inside the frame hides 255
      push_pixel(8'd254, 1'b0); push_pixel(8'd89, 1'b0);  push_pixel(8'd91, 1'b0);
      push_pixel(8'd90, 1'b0);  push_pixel(8'd90, 1'b0);  push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b1); push_pixel(8'd1, 1'b0);   push_pixel(8'd128, 1'b0);
      push_pixel(8'd0, 1'b1);   push_pixel(8'd0, 1'b1);   push_pixel(8'd0, 1'b1);
      push_pixel(8'd0, 1'b1);

      // Random frames; the first phase includes a long receiver hold-off
      configure(12'd4, 12'd5, 8'd90, 8'd255);
      idle_on = 1'b1;
      hold_token++;
      queue_frame(4, 5);
      queue_frame(4, 5);
      run_phase(12'd4, 12'd5, 8'd90, 8'd255, 100, 1'b1);
      run_phase(12'd6, 12'd7, 8'd0, 8'd255, 60, 1'b1);
      run_phase(12'd5, 12'd4, 8'd255, 8'd0, 100, 1'b1);
      run_phase(12'd3, 12'd8, 8'd200, 8'd200, 60, 1'b1);
      run_phase(12'd2, 12'd2, 8'd90, 8'd255, 60, 1'b1);
      // Size extremes: out-of-range values saturate to the smallest legal frame
      run_phase(12'd0, 12'd1, 8'd90, 8'd255, 1, 1'b1);
      run_phase(12'd2, 12'd0, 8'd17, 8'd34, 1, 1'b0);
      // Final stretch with no idling
      run_phase(12'd7, 12'd3, PIX_W'($urandom), PIX_W'($urandom), 100, 1'b0);

      wait_idle();
      if (mismatch_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
